// File: src/pse_pkg.sv
// Shared types, codes and constants of the polyline stroke extruder.
`default_nettype none
package pse_pkg;

	localparam int SLOTS          = 16;
	localparam int SLOT_W         = 4;
	localparam int RESULT_CAP     = 64;
	localparam int DEF_MAX_POINTS = 11;
	localparam int MIN_WINDOW     = 3;
	localparam int VTX_PER_SEG    = 6;
	localparam int UNIT_ONE       = 16384;

	localparam logic [15:0] THICK_RESET = 16'd256;
	localparam logic [4:0]  MAXP_RESET  = 5'd10;

	// Command codes carried on the input tuser.
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Configuration register indexes.
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_THICKNESS  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_POINTS = 1'b1;

	// Output tdata layout.
	localparam int OUT_U_BIT = 32;

	typedef enum logic [14:0] {
		ST_IDLE  = 15'b000000000000001,
		ST_SQ1   = 15'b000000000000010,
		ST_SQ2   = 15'b000000000000100,
		ST_SQRT  = 15'b000000000001000,
		ST_DLOAD = 15'b000000000010000,
		ST_DSTEP = 15'b000000000100000,
		ST_DISP  = 15'b000000001000000,
		ST_DOT1  = 15'b000000010000000,
		ST_DOT2  = 15'b000000100000000,
		ST_OFFX  = 15'b000001000000000,
		ST_OFFY  = 15'b000010000000000,
		ST_EWR   = 15'b000100000000000,
		ST_FIN   = 15'b001000000000000,
		ST_EST   = 15'b010000000000000,
		ST_EMIT  = 15'b100000000000000
	} state_t;

	typedef enum logic [1:0] {
		JOB_FIRST = 2'd0,
		JOB_TURN  = 2'd1,
		JOB_NEW   = 2'd2
	} job_t;

	typedef struct packed {
		logic [7:0] quo;
		logic [3:0] rem;
	} astep_t;

	// 510 divided by the window span d, as quotient and remainder.
	function automatic astep_t alpha_step(input logic [4:0] d);
		astep_t r;
		case (d)
			5'd2:    r = '{quo: 8'd255, rem: 4'd0};
			5'd3:    r = '{quo: 8'd170, rem: 4'd0};
			5'd4:    r = '{quo: 8'd127, rem: 4'd2};
			5'd5:    r = '{quo: 8'd102, rem: 4'd0};
			5'd6:    r = '{quo: 8'd85,  rem: 4'd0};
			5'd7:    r = '{quo: 8'd72,  rem: 4'd6};
			5'd8:    r = '{quo: 8'd63,  rem: 4'd6};
			5'd9:    r = '{quo: 8'd56,  rem: 4'd6};
			5'd10:   r = '{quo: 8'd51,  rem: 4'd0};
			5'd11:   r = '{quo: 8'd46,  rem: 4'd4};
			5'd12:   r = '{quo: 8'd42,  rem: 4'd6};
			5'd13:   r = '{quo: 8'd39,  rem: 4'd3};
			5'd14:   r = '{quo: 8'd36,  rem: 4'd6};
			5'd15:   r = '{quo: 8'd34,  rem: 4'd0};
			default: r = '{quo: 8'd0,   rem: 4'd0};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/polyline_stroke_extruder.sv
// Polyline stroke extruder: turns a trail of points into a triangle list.
//
// Each add item carries one trail point; a clear item empties the history
// and gives no result. A new point is normalised against the previous one
// by a shared unit: two squares on one 18x18 multiplier, a 31-step square
// root and two 16-step restoring divisions on one 62-bit subtractor. The
// same multiplier forms the turn test and the edge offsets. A point that
// repeats the last one is not stored, but the window is still sent. After
// every add item that leaves at least two points in the window, the whole
// window is sent as six vertices per segment, one vertex per cycle while
// the output is taken. An add item that turns a corner runs the normaliser
// twice, for its direction and for the bisector of the two normals, before
// the window read starts; a straight one and the first segment of a trail
// run it once. Each vertex then passes the read stage and the output
// register, and a window holds up to 60 vertices. The input is not ready
// while a point is worked on or its vertices are being read out of the edge
// stores; the last few vertices drain through a read stage and the output
// register while the next item is already accepted. Configuration writes
// are to be made only while the block is idle; the block itself does not
// enforce this. Writing max_points also clears the history.
`default_nettype none
module polyline_stroke_extruder #(
	parameter int MAX_POINTS = pse_pkg::DEF_MAX_POINTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // point_x [15:0], point_y [31:16]
	input  logic [0:0]  s_tuser,    // command [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // vertex_x, vertex_y, tex_u, tex_v, alpha, zero pad
	output logic        m_tlast,    // last vertex of the window
	input  logic        cfg_we,
	input  logic [pse_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import pse_pkg::*;

	// Largest window: the trail store depth and the reply limit bound it.
	localparam int CAP_A   = (MAX_POINTS < SLOTS) ? MAX_POINTS : SLOTS;
	localparam int CAP_B   = (CAP_A < RESULT_CAP / VTX_PER_SEG + 1) ? CAP_A
	                         : RESULT_CAP / VTX_PER_SEG + 1;
	localparam int WIN_CAP = (CAP_B < MIN_WINDOW) ? MIN_WINDOW : CAP_B;

	state_t state_q;
	job_t   job_q;

	// Configuration.
	logic [15:0] thick_q;
	logic [4:0]  maxp_q;

	// History.
	logic [31:0] last_pt_q, last_dir_q;
	logic [4:0]  count_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [19:0] run_len_q;

	// Point under work and normaliser.
	logic signed [15:0] pt_x_q, pt_y_q;
	logic signed [17:0] vx_q, vy_q;
	logic        sel_h_q;
	logic [33:0] sq_q;
	logic [61:0] sr_v_q, sr_r_q, sr_bit_q;
	logic [30:0] root_q;
	logic [30:0] rem_q;
	logic [15:0] low_q, quot_q;
	logic [3:0]  cnt_q;
	logic        div_y_q, neg_q;
	logic signed [15:0] nrm_x_q, nrm_y_q, u_x_q, u_y_q;
	logic signed [35:0] prod_q;

	// Edge job.
	logic signed [15:0] ev_x_q, ev_y_q, ep_x_q, ep_y_q;
	logic signed [16:0] off_x_q, off_y_q;
	logic [SLOT_W-1:0]  eslot_q;

	// Emission.
	logic [SLOT_W-1:0] seg_q;
	logic [2:0]  vtx_q;
	logic [11:0] aq_q;
	logic [3:0]  arem_q;

	// Read stage and output register.
	logic        rd_v_s1, u_s1, last_s1;
	logic [7:0]  alpha_s1;
	logic [31:0] left_s1, right_s1;
	logic [19:0] len_s1;

	// Stores, undefined until written.
	logic [31:0] left_mem  [SLOTS];
	logic [31:0] right_mem [SLOTS];
	logic [19:0] len_mem   [SLOTS];

	// ------------------------------------------------------------------
	// Window size and slots.
	logic [4:0] win, span;
	always_comb begin
		win = (maxp_q < 5'(MIN_WINDOW)) ? 5'(MIN_WINDOW) : maxp_q;
		if (win > 5'(WIN_CAP))
			win = 5'(WIN_CAP);
		span = win - 5'd1;
	end

	logic [SLOT_W-1:0] new_slot, prev_slot;
	assign new_slot  = oldest_q + count_q[SLOT_W-1:0];
	assign prev_slot = new_slot - 1'b1;

	logic signed [15:0] in_x, in_y;
	assign in_x = s_tdata[15:0];
	assign in_y = s_tdata[31:16];

	// Normal of the current direction and the stored previous direction.
	logic signed [17:0] n_x, n_y, o_x, o_y;
	assign n_x = -{{2{u_y_q[15]}}, u_y_q};
	assign n_y = {{2{u_x_q[15]}}, u_x_q};
	assign o_x = {{2{last_dir_q[31]}}, last_dir_q[31:16]};
	assign o_y = {{2{last_dir_q[15]}}, last_dir_q[15:0]};

	// ------------------------------------------------------------------
	// Shared multiplier.
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] mul_p;
	logic [15:0] abs_ev_x, abs_ev_y;
	assign abs_ev_x = ev_x_q[15] ? 16'(-ev_x_q) : ev_x_q;
	assign abs_ev_y = ev_y_q[15] ? 16'(-ev_y_q) : ev_y_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ1:  begin mul_a = vx_q; mul_b = vx_q; end
			ST_SQ2:  begin mul_a = vy_q; mul_b = vy_q; end
			ST_DOT1: begin mul_a = n_x;  mul_b = o_x;  end
			ST_DOT2: begin mul_a = n_y;  mul_b = o_y;  end
			ST_OFFX: begin mul_a = {2'b00, abs_ev_x}; mul_b = {2'b00, thick_q}; end
			ST_OFFY: begin mul_a = {2'b00, abs_ev_y}; mul_b = {2'b00, thick_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------
	// Shared subtractor: square root trial and division trial.
	logic [61:0] sub_a, sub_b;
	logic [62:0] sub_d;
	logic        sub_ge;
	logic [31:0] div_t;
	assign div_t = {rem_q, low_q[15]};

	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = sr_v_q;
			sub_b = sr_r_q + sr_bit_q;
		end else begin
			sub_a = {30'd0, div_t};
			sub_b = {31'd0, root_q};
		end
	end
	assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge = ~sub_d[62];

	logic [61:0] sr_r_next;
	assign sr_r_next = sub_ge ? ((sr_r_q >> 1) + sr_bit_q) : (sr_r_q >> 1);

	logic [33:0] sq_sum;
	assign sq_sum = sq_q + mul_p[33:0];

	// Division load and result.
	logic signed [17:0] dcomp;
	logic [16:0] dmag;
	logic [45:0] dnum;
	assign dcomp = div_y_q ? vy_q : vx_q;
	assign dmag  = dcomp[17] ? 17'(-dcomp) : dcomp[16:0];
	assign dnum  = {1'b0, dmag, 28'd0} + {16'd0, root_q[30:1]};

	logic [15:0] quot_next, quot_clip;
	logic signed [15:0] quot_signed;
	assign quot_next   = {quot_q[14:0], sub_ge};
	assign quot_clip   = (quot_next > 16'(UNIT_ONE)) ? 16'(UNIT_ONE) : quot_next;
	assign quot_signed = neg_q ? 16'(-quot_clip) : quot_clip;

	// Turn test and the bisector input.
	logic signed [35:0] dot_sum;
	assign dot_sum = prod_q + mul_p;

	// Edge offset from the product.
	logic [35:0] off_round;
	logic [16:0] off_mag;
	assign off_round = mul_p + 36'sd16384;
	assign off_mag   = off_round[31:15];

	// Saturated edge vertices.
	function automatic logic [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767)
			return 16'h7fff;
		else if (v < -18'sd32768)
			return 16'h8000;
		else
			return v[15:0];
	endfunction

	logic signed [17:0] ep_xe, ep_ye, of_xe, of_ye;
	assign ep_xe = {{2{ep_x_q[15]}}, ep_x_q};
	assign ep_ye = {{2{ep_y_q[15]}}, ep_y_q};
	assign of_xe = {off_x_q[16], off_x_q};
	assign of_ye = {off_y_q[16], off_y_q};

	logic [31:0] left_wr, right_wr;
	assign left_wr  = {sat16(ep_xe + of_xe), sat16(ep_ye + of_ye)};
	assign right_wr = {sat16(ep_xe - of_xe), sat16(ep_ye - of_ye)};

	// ------------------------------------------------------------------
	// Emission control.
	astep_t astep;
	assign astep = alpha_step(span);

	logic [SLOT_W-1:0] slot_a, slot_b, rd_addr;
	logic use_b, use_u, emit_last, issue, out_load;
	logic [7:0] alpha_seg;
	logic [4:0] arem_sum;

	assign slot_a    = oldest_q + seg_q;
	assign slot_b    = slot_a + 1'b1;
	// Vertex order in a segment: left a, right b, left b, left a, right a, right b.
	assign use_b     = (vtx_q == 3'd1) || (vtx_q == 3'd2) || (vtx_q == 3'd5);
	assign use_u     = (vtx_q == 3'd1) || (vtx_q == 3'd4) || (vtx_q == 3'd5);
	assign rd_addr   = use_b ? slot_b : slot_a;
	assign emit_last = ({1'b0, seg_q} == count_q - 5'd2) && (vtx_q == 3'(VTX_PER_SEG - 1));
	assign alpha_seg = ({seg_q, 1'b0} < span) ? aq_q[7:0] : 8'd255;
	assign arem_sum  = {1'b0, arem_q} + {1'b0, astep.rem};

	assign out_load = rd_v_s1 && (!m_tvalid || m_tready);
	assign issue    = (state_q == ST_EMIT) && (!rd_v_s1 || out_load);

	assign s_tready = (state_q == ST_IDLE);

	// ------------------------------------------------------------------
	// Memories.
	always_ff @(posedge clk) begin
		if (state_q == ST_EWR) begin
			left_mem[eslot_q]  <= left_wr;
			right_mem[eslot_q] <= right_wr;
		end
		if (issue) begin
			left_s1  <= left_mem[rd_addr];
			right_s1 <= right_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN)
			len_mem[new_slot] <= run_len_q;
		if (issue)
			len_s1 <= len_mem[rd_addr];
	end

	// ------------------------------------------------------------------
	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			job_q      <= JOB_NEW;
			thick_q    <= THICK_RESET;
			maxp_q     <= MAXP_RESET;
			last_pt_q  <= '0;
			last_dir_q <= '0;
			count_q    <= '0;
			oldest_q   <= '0;
			run_len_q  <= '0;
			sel_h_q    <= 1'b0;
			div_y_q    <= 1'b0;
			seg_q      <= '0;
			vtx_q      <= '0;
			aq_q       <= '0;
			arem_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_THICKNESS: thick_q <= cfg_data;
					REG_MAX_POINTS: begin
						maxp_q     <= cfg_data[4:0];
						count_q    <= '0;
						oldest_q   <= '0;
						run_len_q  <= '0;
						last_pt_q  <= '0;
						last_dir_q <= '0;
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0] == CMD_CLEAR) begin
							count_q    <= '0;
							oldest_q   <= '0;
							run_len_q  <= '0;
							last_pt_q  <= '0;
							last_dir_q <= '0;
						end else if (count_q == '0) begin
							pt_x_q  <= in_x;
							pt_y_q  <= in_y;
							state_q <= ST_FIN;
						end else if (last_pt_q != {in_x, in_y}) begin
							pt_x_q  <= in_x;
							pt_y_q  <= in_y;
							vx_q    <= {{2{in_x[15]}}, in_x}
							         - {{2{last_pt_q[31]}}, last_pt_q[31:16]};
							vy_q    <= {{2{in_y[15]}}, in_y}
							         - {{2{last_pt_q[15]}}, last_pt_q[15:0]};
							sel_h_q <= 1'b0;
							state_q <= ST_SQ1;
						end else begin
							state_q <= ST_EST;
						end
					end
				end
				ST_SQ1: begin
					sq_q    <= mul_p[33:0];
					state_q <= ST_SQ2;
				end
				ST_SQ2: begin
					sr_v_q   <= {sq_sum, 28'd0};
					sr_r_q   <= '0;
					sr_bit_q <= 62'd1 << 60;
					state_q  <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sub_ge)
						sr_v_q <= sub_d[61:0];
					sr_r_q   <= sr_r_next;
					sr_bit_q <= sr_bit_q >> 2;
					if (sr_bit_q[0]) begin
						root_q  <= sr_r_next[30:0];
						div_y_q <= 1'b0;
						if (sr_r_next == '0) begin
							nrm_x_q <= '0;
							nrm_y_q <= '0;
							state_q <= ST_DISP;
						end else begin
							state_q <= ST_DLOAD;
						end
					end
				end
				ST_DLOAD: begin
					rem_q   <= {1'b0, dnum[45:16]};
					low_q   <= dnum[15:0];
					quot_q  <= '0;
					cnt_q   <= '0;
					neg_q   <= dcomp[17];
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					rem_q  <= sub_ge ? sub_d[30:0] : div_t[30:0];
					quot_q <= quot_next;
					low_q  <= {low_q[14:0], 1'b0};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) begin
						if (!div_y_q) begin
							nrm_x_q <= quot_signed;
							div_y_q <= 1'b1;
							state_q <= ST_DLOAD;
						end else begin
							nrm_y_q <= quot_signed;
							state_q <= ST_DISP;
						end
					end
				end
				ST_DISP: begin
					ep_x_q  <= last_pt_q[31:16];
					ep_y_q  <= last_pt_q[15:0];
					eslot_q <= prev_slot;
					if (!sel_h_q) begin
						u_x_q     <= nrm_x_q;
						u_y_q     <= nrm_y_q;
						run_len_q <= run_len_q + 20'((root_q + 31'd8192) >> 14);
						if (count_q == 5'd1) begin
							// First segment: the start point takes its own normal.
							ev_x_q  <= -nrm_y_q;
							ev_y_q  <= nrm_x_q;
							job_q   <= JOB_FIRST;
							state_q <= ST_OFFX;
						end else begin
							state_q <= ST_DOT1;
						end
					end else begin
						// Bisector of the two normals; a zero sum keeps the new normal.
						if (root_q == '0) begin
							ev_x_q <= n_x[15:0];
							ev_y_q <= n_y[15:0];
						end else begin
							ev_x_q <= nrm_x_q;
							ev_y_q <= nrm_y_q;
						end
						job_q   <= JOB_TURN;
						state_q <= ST_OFFX;
					end
				end
				ST_DOT1: begin
					prod_q  <= mul_p;
					state_q <= ST_DOT2;
				end
				ST_DOT2: begin
					if (dot_sum != '0) begin
						vx_q    <= n_x - o_y;
						vy_q    <= n_y + o_x;
						sel_h_q <= 1'b1;
						state_q <= ST_SQ1;
					end else begin
						ev_x_q  <= n_x[15:0];
						ev_y_q  <= n_y[15:0];
						ep_x_q  <= pt_x_q;
						ep_y_q  <= pt_y_q;
						eslot_q <= new_slot;
						job_q   <= JOB_NEW;
						state_q <= ST_OFFX;
					end
				end
				ST_OFFX: begin
					off_x_q <= ev_x_q[15] ? -$signed(off_mag) : $signed(off_mag);
					state_q <= ST_OFFY;
				end
				ST_OFFY: begin
					off_y_q <= ev_y_q[15] ? -$signed(off_mag) : $signed(off_mag);
					state_q <= ST_EWR;
				end
				ST_EWR: begin
					if (job_q == JOB_NEW) begin
						state_q <= ST_FIN;
					end else begin
						ev_x_q  <= n_x[15:0];
						ev_y_q  <= n_y[15:0];
						ep_x_q  <= pt_x_q;
						ep_y_q  <= pt_y_q;
						eslot_q <= new_slot;
						job_q   <= JOB_NEW;
						state_q <= ST_OFFX;
					end
				end
				ST_FIN: begin
					if (count_q != '0)
						last_dir_q <= {u_x_q, u_y_q};
					last_pt_q <= {pt_x_q, pt_y_q};
					// The window never holds more points than its size; when full the oldest is dropped.
					if (count_q + 5'd1 > win)
						oldest_q <= oldest_q + 1'b1;
					else
						count_q <= count_q + 5'd1;
					state_q <= ST_EST;
				end
				ST_EST: begin
					seg_q  <= '0;
					vtx_q  <= '0;
					aq_q   <= '0;
					arem_q <= '0;
					state_q <= (count_q < 5'd2) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (issue) begin
						if (vtx_q == 3'(VTX_PER_SEG - 1)) begin
							vtx_q <= '0;
							seg_q <= seg_q + 1'b1;
							if (arem_sum >= span) begin
								arem_q <= 4'(arem_sum - span);
								aq_q   <= aq_q + {4'd0, astep.quo} + 12'd1;
							end else begin
								arem_q <= arem_sum[3:0];
								aq_q   <= aq_q + {4'd0, astep.quo};
							end
						end else begin
							vtx_q <= vtx_q + 3'd1;
						end
						if (emit_last)
							state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Read stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (issue)
				rd_v_s1 <= 1'b1;
			else if (out_load)
				rd_v_s1 <= 1'b0;
			if (out_load)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	// The stores keep x in the upper half; the output puts x first.
	always_ff @(posedge clk) begin
		if (issue) begin
			u_s1     <= use_u;
			last_s1  <= emit_last;
			alpha_s1 <= alpha_seg;
		end
		if (out_load) begin
			m_tdata <= {3'd0, alpha_s1, len_s1, u_s1,
			            u_s1 ? {right_s1[15:0], right_s1[31:16]}
			                 : {left_s1[15:0], left_s1[31:16]}};
			m_tlast <= last_s1;
		end
	end

endmodule
`default_nettype wire

// File: src/pse_checker.sv
// Port checker for the polyline stroke extruder, bound to the top level.
`default_nettype none
module pse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_we,
	input logic [pse_pkg::REG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_data
);
	import pse_pkg::*;

	// A stalled vertex holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output vertex changed while stalled");

	// The window always closes on a right edge vertex.
	a_last_right: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[OUT_U_BIT])
		else $error("last vertex is not a right edge vertex");

	// An add item always leaves the block busy in the cycle after it is taken.
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == CMD_ADD) |=> !s_tready)
		else $error("ready stayed high after an add item");

endmodule

bind polyline_stroke_extruder pse_checker u_pse_checker (.*);
`default_nettype wire
